// ----- rtl/kcl_pkg.sv -----
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Phase encoding, event and echo codes, character codes, register indexes
// and reset values of the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

   localparam int SECRET_W  = 16;
   localparam int MAXATT_W  = 4;
   localparam int TICKS_W   = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int FAIL_W    = 4;
   localparam int DIGIT_W   = 4;
   localparam int CHAR_W    = 8;
   localparam int RSP_DATA_W = 16;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_SECRET_CODE   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_ATTEMPTS  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRANT_TICKS   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DENY_TICKS    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOCKOUT_TICKS = 3'd4;

   // Register reset values.
   localparam logic [SECRET_W-1:0] SECRET_RST  = 16'h1234;
   localparam logic [MAXATT_W-1:0] MAXATT_RST  = 4'd3;
   localparam logic [TICKS_W-1:0]  GRANT_RST   = 16'd3000;
   localparam logic [TICKS_W-1:0]  DENY_RST    = 16'd1000;
   localparam logic [TICKS_W-1:0]  LOCKOUT_RST = 16'd3000;

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

   localparam logic [FAIL_W-1:0] FAIL_MAX = 4'd15;

   typedef enum logic [1:0] {
      PH_ENTRY = 2'd0,
      PH_GRANT = 2'd1,
      PH_DENY  = 2'd2,
      PH_LOCK  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ECHO_NONE  = 2'd0,
      ECHO_STAR  = 2'd1,
      ECHO_ERASE = 2'd2
   } echo_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_GRANTED  = 3'd1,
      EV_DENIED   = 3'd2,
      EV_LOCK_BEG = 3'd3,
      EV_RELOCKED = 3'd4,
      EV_LOCK_END = 3'd5
   } event_type;

   // One result transaction, first field in the highest bits.
   typedef struct packed {
      logic            buzzer_on;
      logic            red_led;
      logic            grant_lamp;
      logic [3:0]      attempts_left;
      event_type       event_code;
      echo_type        echo_kind;
   } rsp_type;

   // Expected digit at a code position counted from the last digit.
   // Positions beyond the four secret nibbles expect zero.
   function automatic logic [DIGIT_W-1:0] secret_nibble(
      input logic [SECRET_W-1:0] secret,
      input logic [2:0]          pos
   );
      logic [DIGIT_W-1:0] nib;
      case (pos)
         3'd0:    nib = secret[3:0];
         3'd1:    nib = secret[7:4];
         3'd2:    nib = secret[11:8];
         3'd3:    nib = secret[15:12];
         default: nib = '0;
      endcase
      return nib;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/keypad_code_lock_top.sv -----
// ----------------------------------------------------------------------------
// keypad_code_lock_top: digital combination lock on a character stream
// Digits are collected and compared with a BCD secret; millisecond ticks
// time the grant, denial and lockout phases.
//
//   channel  dir  payload                               accepted when
//   req_     in   tuser: mode, tdata: char_code         tvalid & tready
//   rsp_     out  tdata: echo, event, left, lamps, bz   tvalid & tready
//   csr_     in   addr: register index, wdata           we
//
// For each transaction the lock state is updated at the
// accepting edge and the result is registered at the same edge.
// A two-entry output buffer (output register plus skid register) keeps
// req_tready high while one result waits; it drops only when both are full.
// Reset is synchronous; it restores register defaults and the entry phase.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_code_lock_top #(
   parameter int CODE_DIGITS = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,   // [7:0] char_code
   input  wire logic                         req_tuser,   // [0] mode

   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // [1:0] echo_kind, [4:2] event_code, [8:5] attempts_left, [9] grant_lamp,
   // [10] red_led, [11] buzzer_on, [15:12] zero
   output logic [15:0]                       rsp_tdata,

   input  wire logic                         csr_we,
   input  wire logic [kcl_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [kcl_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import kcl_pkg::*;

   localparam int CNT_W = $clog2(CODE_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_DIGITS);

   // Configuration registers.
   logic [SECRET_W-1:0] secret_ff;
   logic [MAXATT_W-1:0] max_att_ff;
   logic [TICKS_W-1:0]  grant_ff;
   logic [TICKS_W-1:0]  deny_ff;
   logic [TICKS_W-1:0]  lockout_ff;

   // Lock state.
   logic [DIGIT_W-1:0] digits_ff [CODE_DIGITS];
   logic [DIGIT_W-1:0] digits_in [CODE_DIGITS];
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FAIL_W-1:0]  failed_ff, failed_in;
   phase_type          phase_ff, phase_in;
   logic [TICKS_W-1:0] timer_ff, timer_in;

   // Output buffer.
   rsp_type rsp_out_ff, rsp_skid_ff, rsp_new;
   logic    out_v_ff, skid_v_ff;

   logic    accept;
   logic    pop;

   // Next-state scratch values.
   logic [DIGIT_W-1:0] digits_wr [CODE_DIGITS];
   logic [CNT_W-1:0]   cnt_wr;
   logic               is_digit;
   logic               match;
   logic               do_submit;
   logic [FAIL_W-1:0]  failed_inc;
   logic [2:0]         pos;

   assign req_tready = !skid_v_ff;
   assign accept     = req_tvalid && req_tready;
   assign pop        = out_v_ff && rsp_tready;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_type)){1'b0}}, rsp_out_ff};

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         secret_ff  <= SECRET_RST;
         max_att_ff <= MAXATT_RST;
         grant_ff   <= GRANT_RST;
         deny_ff    <= DENY_RST;
         lockout_ff <= LOCKOUT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SECRET_CODE:   secret_ff  <= csr_wdata[SECRET_W-1:0];
            CSR_MAX_ATTEMPTS:  max_att_ff <= csr_wdata[MAXATT_W-1:0];
            CSR_GRANT_TICKS:   grant_ff   <= csr_wdata[TICKS_W-1:0];
            CSR_DENY_TICKS:    deny_ff    <= csr_wdata[TICKS_W-1:0];
            CSR_LOCKOUT_TICKS: lockout_ff <= csr_wdata[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // Next state and result of one transaction.
   always_comb begin
      is_digit   = (req_tdata >= CH_ZERO) && (req_tdata <= CH_NINE);
      failed_inc = (failed_ff == FAIL_MAX) ? FAIL_MAX : failed_ff + 1'b1;

      // A digit is written before the compare so the final digit counts.
      cnt_wr = cnt_ff;
      for (int i = 0; i < CODE_DIGITS; i++) begin
         digits_wr[i] = digits_ff[i];
      end
      if (phase_ff == PH_ENTRY && !req_tuser && is_digit && cnt_ff < CNT_FULL) begin
         for (int i = 0; i < CODE_DIGITS; i++) begin
            if (cnt_ff == CNT_W'(i)) begin
               digits_wr[i] = req_tdata[DIGIT_W-1:0];
            end
         end
         cnt_wr = cnt_ff + 1'b1;
      end

      match = (cnt_wr == CNT_FULL);
      for (int i = 0; i < CODE_DIGITS; i++) begin
         pos = 3'(CODE_DIGITS - 1 - i);
         if (digits_wr[i] != secret_nibble(secret_ff, pos)) begin
            match = 1'b0;
         end
      end

      digits_in = digits_wr;
      cnt_in    = cnt_ff;
      failed_in = failed_ff;
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      do_submit = 1'b0;
      rsp_new.echo_kind     = ECHO_NONE;
      rsp_new.event_code    = EV_NONE;
      rsp_new.attempts_left = '0;

      if (req_tuser) begin
         if (phase_ff != PH_ENTRY) begin
            if (timer_ff > 16'd1) begin
               timer_in = timer_ff - 1'b1;
            end else begin
               timer_in = '0;
               case (phase_ff)
                  PH_GRANT: begin
                     phase_in = PH_ENTRY;
                     rsp_new.event_code = EV_RELOCKED;
                  end
                  PH_DENY: begin
                     if (failed_ff >= max_att_ff) begin
                        phase_in = PH_LOCK;
                        timer_in = lockout_ff;
                        rsp_new.event_code = EV_LOCK_BEG;
                     end else begin
                        phase_in = PH_ENTRY;
                     end
                  end
                  default: begin
                     failed_in = '0;
                     phase_in  = PH_ENTRY;
                     rsp_new.event_code = EV_LOCK_END;
                  end
               endcase
            end
         end
      end else if (phase_ff == PH_ENTRY) begin
         if (req_tdata == CH_CR) begin
            do_submit = 1'b1;
         end else if (req_tdata == CH_BS || req_tdata == CH_DEL) begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
               rsp_new.echo_kind = ECHO_ERASE;
            end
         end else if (is_digit) begin
            cnt_in = cnt_wr;
            rsp_new.echo_kind = ECHO_STAR;
            do_submit = (cnt_wr >= CNT_FULL);
         end
      end

      if (do_submit) begin
         cnt_in = '0;
         if (match) begin
            failed_in = '0;
            phase_in  = PH_GRANT;
            timer_in  = grant_ff;
            rsp_new.event_code = EV_GRANTED;
         end else begin
            failed_in = failed_inc;
            phase_in  = PH_DENY;
            timer_in  = deny_ff;
            rsp_new.event_code = EV_DENIED;
            rsp_new.attempts_left = (max_att_ff > failed_inc) ?
                                    max_att_ff - failed_inc : '0;
         end
      end

      rsp_new.grant_lamp = (phase_in == PH_GRANT);
      rsp_new.red_led    = (phase_in != PH_GRANT);
      rsp_new.buzzer_on  = (phase_in == PH_DENY) || (phase_in == PH_LOCK);
   end

   // Lock state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         failed_ff <= '0;
         phase_ff  <= PH_ENTRY;
         timer_ff  <= '0;
      end else if (accept) begin
         cnt_ff    <= cnt_in;
         failed_ff <= failed_in;
         phase_ff  <= phase_in;
         timer_ff  <= timer_in;
      end
   end

   // The entered digits hold no defined value until written.
   always_ff @(posedge clock) begin
      if (accept) begin
         digits_ff <= digits_in;
      end
   end

   // Output register with a skid stage behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (pop) begin
            skid_v_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_v_ff || pop) begin
            out_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (pop) begin
            rsp_out_ff <= rsp_skid_ff;
         end
      end else if (accept) begin
         if (!out_v_ff || pop) begin
            rsp_out_ff <= rsp_new;
         end else begin
            rsp_skid_ff <= rsp_new;
         end
      end
   end

   // The skid stage only fills behind a waiting result.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry valid without a valid output entry");

   // Entry phase never carries a running timer.
   a_entry_timer_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ENTRY) |-> (timer_ff == '0))
      else $error("timer running in entry phase");

   // A full code is always submitted at once, so the count stays short of it.
   a_count_short: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_FULL)
      else $error("digit count reached the code length");

   // A stalled result that cannot move keeps the input side closed.
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (skid_v_ff && !rsp_tready) |=> skid_v_ff && !req_tready)
      else $error("buffer lost an entry while stalled");

endmodule

`default_nettype wire
